// File: design/fish_pkg.sv
// Shared types, constants and codes for the flux interval scatter histogram.
// Used by every module of the block; depends on nothing else.
package fish_pkg;

    localparam int IMG_WIDTH_DEF  = 512;
    localparam int IMG_HEIGHT_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int XSPAN_W    = 20;
    localparam int YSPAN_W    = 10;
    localparam int RATE_W     = 21;
    localparam int COL_IN_W   = 9;
    localparam int ROW_IN_W   = 8;
    localparam int PIX_W      = 8;
    localparam int TIME_W     = 48;
    localparam int CELLS_W    = 24;
    localparam int FRAC_W     = 16;

    localparam int NUM_W = 64;
    localparam int DEN_W = 36;

    localparam logic [CFG_IDX_W-1:0] CFG_X_SPAN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SPAN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIX_RATE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_RATE = 2'd3;

    localparam logic [XSPAN_W-1:0] X_SPAN_RST   = 20'd200000;
    localparam logic [YSPAN_W-1:0] Y_SPAN_RST   = 10'd16;
    localparam logic [RATE_W-1:0]  FIX_RATE_RST = 21'd250000;

    localparam logic [NUM_W-1:0] US_PER_S   = 64'd1000000;
    localparam logic [NUM_W-1:0] STEP_NUM   = 64'd500000 << FRAC_W;
    localparam logic [PIX_W-1:0] PIX_WHITE  = 8'd255;
    localparam logic [PIX_W-1:0] GREY_OFFS  = 8'd40;
    localparam logic [PIX_W-1:0] GREY_BASE  = PIX_WHITE - GREY_OFFS;

    typedef enum logic [1:0] {
        SEL_STEP,
        SEL_COL,
        SEL_Q
    } fish_sel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DSTEP,
        ST_DCOL,
        ST_DQ,
        ST_ADDR,
        ST_RD,
        ST_WR,
        ST_UPD,
        ST_FIN
    } fish_state_t;

    typedef struct packed {
        logic      clr;
        logic      accept;
        logic      div_start;
        fish_sel_t start_sel;
        logic      cap;
        fish_sel_t cap_sel;
        logic      addr_ld;
        logic      mem_rd;
        logic      mem_wr;
        logic      upd;
        logic      out_ld;
    } fish_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic func;
        logic data_bit;
        logic hit;
        logic out_busy;
    } fish_sts_t;

endpackage

// File: design/fish_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on fish_pkg for the operand widths.
module fish_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fish_pkg::NUM_W-1:0] num,
    input  logic [fish_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [fish_pkg::NUM_W-1:0] quo
);
    import fish_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], ge};
        end
        else if (start)
        begin
            rem_reg <= '0;
            num_reg <= num;
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

// File: design/fish_dp.sv
// Datapath: configuration registers, time and cell counters, divider operands,
// histogram store and output register. Depends on fish_pkg and fish_div.
module fish_dp #(
    parameter int IMG_WIDTH  = fish_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = fish_pkg::IMG_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fish_pkg::fish_cmd_t             cmd,
    output fish_pkg::fish_sts_t             sts,
    input  logic                            cfg_wr_en,
    input  logic [fish_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fish_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            func,
    input  logic                            data_bit,
    input  logic [fish_pkg::RATE_W-1:0]     cell_rate,
    input  logic [fish_pkg::COL_IN_W-1:0]   read_col,
    input  logic [fish_pkg::ROW_IN_W-1:0]   read_row,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            trace_full,
    output logic [fish_pkg::PIX_W-1:0]      pix_red,
    output logic [fish_pkg::PIX_W-1:0]      pix_green,
    output logic [fish_pkg::PIX_W-1:0]      pix_blue
);
    import fish_pkg::*;

    localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(IMG_WIDTH);
    localparam int RW    = $clog2(IMG_HEIGHT);
    localparam logic [AW-1:0]    CLR_LAST = AW'(DEPTH - 1);
    localparam logic [AW-1:0]    W_A      = AW'(IMG_WIDTH);
    localparam logic [NUM_W-1:0] W_N      = NUM_W'(IMG_WIDTH);
    localparam logic [NUM_W-1:0] H_N      = NUM_W'(IMG_HEIGHT);
    localparam logic [NUM_W-1:0] Q_K      = US_PER_S * H_N;

    logic [XSPAN_W-1:0]  x_span_reg;
    logic [YSPAN_W-1:0]  y_span_reg;
    logic [RATE_W-1:0]   fix_rate_reg;
    logic                use_rate_reg;

    logic                func_reg;
    logic                data_bit_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [COL_IN_W-1:0] rcol_reg;
    logic [ROW_IN_W-1:0] rrow_reg;

    logic [TIME_W-1:0]   elapsed_reg;
    logic [TIME_W-1:0]   elapsed_next;
    logic [CELLS_W-1:0]  cells_reg;
    logic                full_reg;

    logic [DEN_W-1:0]    step_reg;
    logic [CW-1:0]       col_reg;
    logic                col_lt_reg;
    logic                col_gt_reg;
    logic [RW-1:0]       row_reg;
    logic                q_ok_reg;

    logic [AW-1:0]       addr_reg;
    logic                hit_reg;
    logic                oob_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [PIX_W-1:0]    rd_reg;
    logic [PIX_W-1:0]    mem [DEPTH];

    logic                out_valid_reg;
    logic                full_out_reg;
    logic [PIX_W-1:0]    pix_reg;

    logic [RATE_W-1:0]   rate_sel;
    logic [XSPAN_W-1:0]  x_min;
    logic [YSPAN_W-1:0]  y_min;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_done;
    logic [NUM_W-1:0]    div_quo;
    logic [NUM_W-1:0]    row_diff;
    logic [TIME_W:0]     time_sum;
    logic [PIX_W-1:0]    pix_val;

    assign rate_sel = use_rate_reg ? cell_rate : fix_rate_reg;
    assign x_min    = (x_span_reg == '0) ? XSPAN_W'(1) : x_span_reg;
    assign y_min    = (y_span_reg == '0) ? YSPAN_W'(1) : y_span_reg;

    always_comb
    begin
        case (cmd.start_sel)
            SEL_COL:
            begin
                div_num = NUM_W'(elapsed_reg) * W_N;
                div_den = {DEN_W'(x_min)} << FRAC_W;
            end
            SEL_Q:
            begin
                div_num = NUM_W'(cells_reg) * Q_K;
                div_den = DEN_W'(rate_reg) * DEN_W'(y_min);
            end
            default:
            begin
                div_num = STEP_NUM;
                div_den = DEN_W'(rate_reg);
            end
        endcase
    end

    fish_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign row_diff = H_N - div_quo;
    assign time_sum = {1'b0, elapsed_reg} + (TIME_W + 1)'(step_reg);
    assign elapsed_next = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];
    assign pix_val = (oob_reg || rd_reg == '0) ? PIX_WHITE : GREY_BASE - rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_span_reg    <= X_SPAN_RST;
            y_span_reg    <= Y_SPAN_RST;
            fix_rate_reg  <= FIX_RATE_RST;
            use_rate_reg  <= 1'b0;
            elapsed_reg   <= '0;
            cells_reg     <= '0;
            full_reg      <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_X_SPAN:   x_span_reg   <= cfg_wdata[XSPAN_W-1:0];
                    CFG_Y_SPAN:   y_span_reg   <= cfg_wdata[YSPAN_W-1:0];
                    CFG_FIX_RATE: fix_rate_reg <= cfg_wdata[RATE_W-1:0];
                    CFG_USE_RATE: use_rate_reg <= cfg_wdata[0];
                    default:      ;
                endcase
            end
            if (cmd.clr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.upd)
            begin
                elapsed_reg <= elapsed_next;
                if (data_bit_reg)
                begin
                    cells_reg <= '0;
                    if (col_gt_reg)
                    begin
                        full_reg <= 1'b1;
                    end
                end
                else if (cells_reg != {CELLS_W{1'b1}})
                begin
                    cells_reg <= cells_reg + 1'b1;
                end
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg     <= func;
            data_bit_reg <= data_bit;
            rate_reg     <= (rate_sel == '0) ? RATE_W'(1) : rate_sel;
            rcol_reg     <= read_col;
            rrow_reg     <= read_row;
        end
        if (cmd.cap)
        begin
            case (cmd.cap_sel)
                SEL_COL:
                begin
                    col_reg    <= div_quo[CW-1:0];
                    col_lt_reg <= div_quo < W_N;
                    col_gt_reg <= div_quo > W_N;
                end
                SEL_Q:
                begin
                    row_reg  <= row_diff[RW-1:0];
                    q_ok_reg <= (div_quo != '0) && (div_quo <= H_N);
                end
                default:
                begin
                    step_reg <= div_quo[DEN_W-1:0];
                end
            endcase
        end
        if (cmd.addr_ld)
        begin
            if (func_reg)
            begin
                addr_reg <= AW'(rrow_reg) * W_A + AW'(rcol_reg);
                oob_reg  <= (rcol_reg >= IMG_WIDTH) || (rrow_reg >= IMG_HEIGHT);
                hit_reg  <= 1'b0;
            end
            else
            begin
                addr_reg <= AW'(row_reg) * W_A + AW'(col_reg);
                oob_reg  <= 1'b0;
                hit_reg  <= col_lt_reg && q_ok_reg;
            end
        end
        if (cmd.out_ld)
        begin
            full_out_reg <= full_reg;
            pix_reg      <= func_reg ? pix_val : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.mem_wr)
        begin
            mem[addr_reg] <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rd_reg <= mem[addr_reg];
        end
    end

    assign sts.clr_last = clr_addr_reg == CLR_LAST;
    assign sts.div_done = div_done;
    assign sts.func     = func_reg;
    assign sts.data_bit = data_bit_reg;
    assign sts.hit      = hit_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign trace_full = full_out_reg;
    assign pix_red    = pix_reg;
    assign pix_green  = pix_reg;
    assign pix_blue   = pix_reg;

endmodule

// File: design/fish_ctrl.sv
// Controller state machine: store clearing, divider sequencing, store update
// and result hand-off. Depends on fish_pkg.
module fish_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fish_pkg::fish_sts_t sts,
    output fish_pkg::fish_cmd_t cmd
);
    import fish_pkg::*;

    fish_state_t state_reg;
    fish_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.clr       = 1'b0;
        cmd.accept    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.start_sel = SEL_STEP;
        cmd.cap       = 1'b0;
        cmd.cap_sel   = SEL_STEP;
        cmd.addr_ld   = 1'b0;
        cmd.mem_rd    = 1'b0;
        cmd.mem_wr    = 1'b0;
        cmd.upd       = 1'b0;
        cmd.out_ld    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                if (sts.func)
                begin
                    cmd.addr_ld = 1'b1;
                    state_next  = ST_RD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.start_sel = SEL_STEP;
                    state_next    = ST_DSTEP;
                end
            end
            ST_DSTEP:
            begin
                cmd.start_sel = SEL_COL;
                if (sts.div_done)
                begin
                    cmd.cap     = 1'b1;
                    cmd.cap_sel = SEL_STEP;
                    if (sts.data_bit)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DCOL;
                    end
                    else
                    begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_DCOL:
            begin
                cmd.start_sel = SEL_Q;
                if (sts.div_done)
                begin
                    cmd.cap       = 1'b1;
                    cmd.cap_sel   = SEL_COL;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DQ;
                end
            end
            ST_DQ:
            begin
                if (sts.div_done)
                begin
                    cmd.cap     = 1'b1;
                    cmd.cap_sel = SEL_Q;
                    state_next  = ST_WR;
                end
            end
            ST_WR:
            begin
                cmd.addr_ld = 1'b1;
                state_next  = ST_RD;
            end
            ST_RD:
            begin
                cmd.mem_rd = 1'b1;
                if (sts.func)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                cmd.mem_wr = sts.hit && sts.data_bit;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_ADDR))
        else $error("accepted transfer did not start processing");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> !sts.out_busy)
        else $error("result loaded over a pending transfer");
    a_wr_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> (sts.hit && !sts.func && $past(cmd.mem_rd)))
        else $error("store written without a hit read");
    a_cap_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap |-> sts.div_done)
        else $error("quotient captured before the divider finished");
`endif

endmodule

// File: design/flux_interval_scatter_histogram.sv
// Flux interval scatter histogram: top level joining controller and datapath.
// Depends on fish_pkg, fish_ctrl, fish_dp and fish_div.
//
// Input items arrive on a valid/ready channel (in_valid, in_ready). func 0
// processes one track cell; func 1 reads one pixel at read_col, read_row.
// Every item gives one result on the out_valid/out_ready channel: trace_full
// and, for a pixel read, the grey or white colour; for a cell, zero pixels.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata.
//
// After reset the histogram store is cleared one entry per cycle, all
// IMG_WIDTH*IMG_HEIGHT entries (131072 by default); in_ready stays low until
// then. Configuration writes are taken at any time.
//
// A cell goes through the shared restoring divider, which makes one quotient
// bit per cycle over 64 bits: one division for a plain (non-pulse) cell, three
// for a pulse cell. A pixel read goes through the registered store read. One
// item is in work at a time; a finished result sits in the output register,
// so the next transfer is accepted while it waits. A stalled receiver holds
// the block only when a further result is ready to be loaded.
module flux_interval_scatter_histogram #(
    parameter int IMG_WIDTH  = fish_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = fish_pkg::IMG_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [fish_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fish_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic                            data_bit,
    input  logic [fish_pkg::RATE_W-1:0]     cell_rate,
    input  logic [fish_pkg::COL_IN_W-1:0]   read_col,
    input  logic [fish_pkg::ROW_IN_W-1:0]   read_row,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            trace_full,
    output logic [fish_pkg::PIX_W-1:0]      pix_red,
    output logic [fish_pkg::PIX_W-1:0]      pix_green,
    output logic [fish_pkg::PIX_W-1:0]      pix_blue
);
    import fish_pkg::*;

    fish_cmd_t cmd;
    fish_sts_t sts;

    fish_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fish_dp #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .func       (func),
        .data_bit   (data_bit),
        .cell_rate  (cell_rate),
        .read_col   (read_col),
        .read_row   (read_row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .trace_full (trace_full),
        .pix_red    (pix_red),
        .pix_green  (pix_green),
        .pix_blue   (pix_blue)
    );

endmodule
